### hw/rtl/sep7_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_pkg: shared definitions for the separable 7-tap image filter
// Frame geometry, tap count, datapath widths, reset weights and the
// control bundle that drives the line-store cells.
// ----------------------------------------------------------------------------
package sep7_pkg;

  // Frame geometry.
  localparam int IMAGE_WIDTH  = 480;
  localparam int IMAGE_HEIGHT = 270;

  // Filter shape.
  localparam int TAPS      = 7;
  localparam int HIST      = TAPS - 1;
  localparam int OUT_WIDTH = IMAGE_WIDTH - HIST;

  // Datapath widths.
  localparam int PIX_W   = 8;
  localparam int PROD_W  = 2 * PIX_W;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int SUM_W   = PROD_W + $clog2(TAPS);
  localparam int SHIFT   = 8;
  localparam int COL_W   = $clog2(IMAGE_WIDTH);
  localparam int ROW_W   = $clog2(IMAGE_HEIGHT);
  localparam int HX_W    = $clog2(OUT_WIDTH);
  localparam int CIDX_W  = $clog2(TAPS);

  // Pipeline depth from the window register to the result register.
  localparam int NSTAGE = 7;

  // Tap weights after reset, oldest position first.
  localparam logic [PIX_W-1:0] COEF_RESET [TAPS] =
    '{8'd2, 8'd15, 8'd62, 8'd98, 8'd62, 8'd15, 8'd2};

  // Per-beat bookkeeping that travels with a pixel down the pipeline.
  typedef struct packed {
    logic [HX_W-1:0] hx;
    logic            produce;
    logic            row_end;
    logic            frame_end;
  } tag_t;

  // Read and write control shared by every line-store cell.
  typedef struct packed {
    logic            re;
    logic            we;
    logic [HX_W-1:0] raddr;
    logic [HX_W-1:0] waddr;
  } ls_ctrl_t;

endpackage

### hw/rtl/separable_7tap_image_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_7tap_image_filter: 7x7 separable FIR filter over a pixel stream
//
//   Channel  Handshake               Payload
//   -------  ----------------------  -----------------------------------
//   pixel    pix_valid / pix_ready   pixel_in
//   result   res_valid / res_ready   pixel_out, row_end, frame_end
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel beat is taken every clock while the pipeline moves; the beat
// that completes a 7x7 window reaches the result register through the
// seven-stage pipeline: window cells, products, pair sums, horizontal
// sum with line-store read, vertical products, pair sums, result
// register. Each stage holds its beat while the one
// after it is full, so bubbles collapse and a stall only reaches the input
// once every stage is occupied. Reset clears the counters and the stage
// valid bits and reloads the weights; the line stores hold no state needing
// reset.
// ----------------------------------------------------------------------------
module separable_7tap_image_filter import sep7_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // Pixel input.
  input  logic              pix_valid,
  output logic              pix_ready,
  input  logic [PIX_W-1:0]  pixel_in,
  // Filtered output.
  output logic              res_valid,
  input  logic              res_ready,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              row_end,
  output logic              frame_end,
  // Weight writes.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]  cfg_data
);

  logic [PIX_W-1:0]  coef [TAPS];
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [NSTAGE:1]   vld;
  logic [NSTAGE:1]   en;
  tag_t              tag [1:NSTAGE];
  tag_t              tag_in;
  logic              pix_accept;
  logic [PIX_W-1:0]  win [TAPS];
  logic [PROD_W-1:0] hprod [TAPS];
  logic [SUM_W-1:0]  hsum;
  logic [PIX_W-1:0]  h;
  ls_ctrl_t          ls;
  logic [PIX_W-1:0]  vold [HIST];
  logic [PROD_W-1:0] vprod [TAPS];
  logic [PROD_W-1:0] vprod_top;
  logic [SUM_W-1:0]  vsum;

  // Weight registers; writes beyond the last tap are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        coef[i] <= COEF_RESET[i];
      end
    end else if (cfg_valid && (cfg_index < CIDX_W'(TAPS))) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || res_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_ready  = en[1];
  assign pix_accept = pix_valid && pix_ready;

  // Raster position of the next pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (pix_accept) begin
      if (col == COL_W'(IMAGE_WIDTH - 1)) begin
        col <= '0;
        if (row == ROW_W'(IMAGE_HEIGHT - 1)) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Bookkeeping for the beat entering the first stage.
  always_comb begin
    tag_in.hx        = HX_W'(col - COL_W'(HIST));
    tag_in.produce   = (row >= ROW_W'(HIST));
    tag_in.row_end   = (col == COL_W'(IMAGE_WIDTH - 1));
    tag_in.frame_end = (col == COL_W'(IMAGE_WIDTH - 1)) &&
                       (row == ROW_W'(IMAGE_HEIGHT - 1));
  end

  // Stage valid bits; beats before the row's window fills never enter, and
  // beats above the seventh row of the frame drop out before the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= pix_valid && (col >= COL_W'(HIST));
      end
      for (int k = 2; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (en[NSTAGE]) begin
        vld[NSTAGE] <= vld[NSTAGE-1] && tag[NSTAGE-1].produce;
      end
    end
  end

  // Bookkeeping follows its beat.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag[1] <= tag_in;
    end
    for (int k = 2; k <= NSTAGE; k++) begin
      if (en[k]) begin
        tag[k] <= tag[k-1];
      end
    end
  end

  // Horizontal window: a chain of pixel cells, newest at the top.
  for (genvar i = 0; i < TAPS; i++) begin : g_hcell
    logic [PIX_W-1:0] next_pix;
    if (i == TAPS - 1) begin : g_newest
      assign next_pix = pixel_in;
    end else begin : g_older
      assign next_pix = win[i+1];
    end
    sep7_hcell u_hcell (
      .clk     (clk),
      .shift   (pix_accept),
      .pix_in  (next_pix),
      .coef    (coef[i]),
      .prod_en (en[2]),
      .pix     (win[i]),
      .prod    (hprod[i])
    );
  end

  // Horizontal sum; its register is the fourth stage.
  sep7_sum7 u_hsum (
    .clk  (clk),
    .en_a (en[3]),
    .en_b (en[4]),
    .prod (hprod),
    .sum  (hsum)
  );

  assign h = hsum[SHIFT +: PIX_W];

  // Line stores are read as a beat enters the fourth stage and written
  // as it leaves, so the read data sits beside the horizontal result.
  always_comb begin
    ls.re    = en[4] && vld[3];
    ls.we    = vld[4] && en[5];
    ls.raddr = tag[3].hx;
    ls.waddr = tag[4].hx;
  end

  // Vertical chain: each cell stores what its newer neighbor held.
  for (genvar j = 0; j < HIST; j++) begin : g_vcell
    logic [PIX_W-1:0] down;
    if (j == HIST - 1) begin : g_newest
      assign down = h;
    end else begin : g_older
      assign down = vold[j+1];
    end
    sep7_vcell u_vcell (
      .clk     (clk),
      .ctrl    (ls),
      .wr_data (down),
      .coef    (coef[j]),
      .prod_en (en[5]),
      .rd_data (vold[j]),
      .prod    (vprod[j])
    );
  end

  // Newest vertical tap uses the fresh horizontal result.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      vprod_top <= PROD_W'(coef[TAPS-1]) * PROD_W'(h);
    end
  end

  assign vprod[TAPS-1] = vprod_top;

  // Vertical sum; its register is the result register.
  sep7_sum7 u_vsum (
    .clk  (clk),
    .en_a (en[6]),
    .en_b (en[7]),
    .prod (vprod),
    .sum  (vsum)
  );

  assign res_valid = vld[NSTAGE];
  assign pixel_out = vsum[SHIFT +: PIX_W];
  assign row_end   = tag[NSTAGE].row_end;
  assign frame_end = tag[NSTAGE].frame_end;

  // A column is never read in the same cycle that its update lands.
  a_ls_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ls.re && ls.we) |-> (ls.raddr != ls.waddr))
    else $error("line-store read and write hit the same column");

  // Beats in the pipeline always address a column inside the line store.
  a_hx_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (tag[1].hx <= HX_W'(OUT_WIDTH - 1)))
    else $error("column index beyond line-store depth");

  // The raster position stays inside the frame.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (col <= COL_W'(IMAGE_WIDTH - 1)) && (row <= ROW_W'(IMAGE_HEIGHT - 1)))
    else $error("raster position outside the frame");

  // A frame end is always the end of a row.
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_end) |-> row_end)
    else $error("frame end flagged without row end");

endmodule

### hw/rtl/sep7_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and only
// updates when the read enable is high.
// ----------------------------------------------------------------------------
module sep7_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sep7_hcell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_hcell: one cell of the horizontal pixel window
// Holds one pixel of the current row, hands it to its older neighbor on
// every accepted beat, and registers the weighted product of its pixel.
// ----------------------------------------------------------------------------
module sep7_hcell import sep7_pkg::*; (
  input  logic              clk,
  input  logic              shift,
  input  logic [PIX_W-1:0]  pix_in,
  input  logic [PIX_W-1:0]  coef,
  input  logic              prod_en,
  output logic [PIX_W-1:0]  pix,
  output logic [PROD_W-1:0] prod
);

  // Window shift: take the pixel of the newer neighbor.
  always_ff @(posedge clk) begin
    if (shift) begin
      pix <= pix_in;
    end
  end

  // Tap product for the window held in the cells.
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= PROD_W'(coef) * PROD_W'(pix);
    end
  end

endmodule

### hw/rtl/sep7_vcell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_vcell: one cell of the vertical line-store chain
// Holds one row of horizontal results. Each beat reads the old entry of its
// column, passes it on to the older neighbor, stores the entry handed down
// by the newer neighbor, and registers the weighted product of the old entry.
// ----------------------------------------------------------------------------
module sep7_vcell import sep7_pkg::*; (
  input  logic              clk,
  input  ls_ctrl_t          ctrl,
  input  logic [PIX_W-1:0]  wr_data,
  input  logic [PIX_W-1:0]  coef,
  input  logic              prod_en,
  output logic [PIX_W-1:0]  rd_data,
  output logic [PROD_W-1:0] prod
);

  // Row storage for this cell.
  sep7_ram #(
    .WIDTH (PIX_W),
    .DEPTH (OUT_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.we),
    .waddr (ctrl.waddr),
    .wdata (wr_data),
    .re    (ctrl.re),
    .raddr (ctrl.raddr),
    .rdata (rd_data)
  );

  // Tap product of the stored entry.
  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= PROD_W'(coef) * PROD_W'(rd_data);
    end
  end

endmodule

### hw/rtl/sep7_sum7.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sep7_sum7: two-stage adder tree over the seven tap products
// The first stage forms pair sums, the second adds the pairs.
// ----------------------------------------------------------------------------
module sep7_sum7 import sep7_pkg::*; (
  input  logic              clk,
  input  logic              en_a,
  input  logic              en_b,
  input  logic [PROD_W-1:0] prod [TAPS],
  output logic [SUM_W-1:0]  sum
);

  logic [PAIR_W-1:0] pair [4];

  // Pair sums of neighboring taps; the last tap stands alone.
  always_ff @(posedge clk) begin
    if (en_a) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
      pair[2] <= PAIR_W'(prod[4]) + PAIR_W'(prod[5]);
      pair[3] <= PAIR_W'(prod[6]);
    end
  end

  // Final sum of the pairs.
  always_ff @(posedge clk) begin
    if (en_b) begin
      sum <= (SUM_W'(pair[0]) + SUM_W'(pair[1])) +
             (SUM_W'(pair[2]) + SUM_W'(pair[3]));
    end
  end

endmodule
